>>> rtl/pamf_pkg.sv
// pamf_pkg: shared types and constants for the proxy arp and mac forward block
// holds job and state types, frame layout offsets and field codes
// no dependencies
package pamf_pkg;

    // input command codes
    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_TABLE = 1'b1;

    // result action codes
    localparam logic ACT_REPLY   = 1'b0;
    localparam logic ACT_FORWARD = 1'b1;

    // configuration register select (address bit 3)
    localparam int   CFG_ADDR_W  = 4;
    localparam int   CFG_SEL_BIT = 3;
    localparam logic REG_OWN_MAC = 1'b0;
    localparam logic REG_OWN_IP  = 1'b1;

    // frame length handling
    localparam logic [5:0] LEN_MAX     = 6'd63;
    localparam logic [5:0] ARP_LEN     = 6'd42;
    localparam logic [5:0] ETH_HDR_LEN = 6'd14;

    // byte offsets of captured header fields
    localparam logic [5:0] POS_SRC_MAC  = 6'd6;
    localparam logic [5:0] POS_TYPES    = 6'd12;
    localparam logic [5:0] POS_SIZES    = 6'd18;
    localparam logic [5:0] POS_SND_MAC  = 6'd22;
    localparam logic [5:0] POS_SND_IP   = 6'd28;
    localparam logic [5:0] POS_TGT_MAC  = 6'd32;
    localparam logic [5:0] POS_TGT_IP   = 6'd38;

    // header field values
    localparam logic [47:0] BCAST_MAC     = 48'hFFFF_FFFF_FFFF;
    localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
    localparam logic [15:0] PTYPE_IPV4    = 16'h0800;
    localparam logic [15:0] HTYPE_ETH     = 16'h0001;
    localparam logic [15:0] OPER_REQUEST  = 16'h0001;
    localparam logic [7:0]  HSIZE_ETH     = 8'd6;
    localparam logic [7:0]  PSIZE_IPV4    = 8'd4;

    // depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        JOB_WRITE,
        JOB_ARP,
        JOB_FWD
    } t_job_op;

    // one queued job: a table write or a peer scan
    typedef struct packed {
        t_job_op     op;
        logic [2:0]  idx;
        logic [47:0] mac;   // entry mac, or captured destination mac
        logic [31:0] ip;    // entry ip, or captured target ip
        logic        flag;  // entry valid, or destination is broadcast
    } t_job;

    typedef enum logic {
        BACK_IDLE,
        BACK_SCAN
    } t_back_state;

endpackage

>>> rtl/pamf_in_if.sv
// pamf_in_if: input channel carrying frame bytes and peer table writes
// uses no package
interface pamf_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [2:0]  entry_index;
    logic [47:0] entry_mac;
    logic [31:0] entry_ip;
    logic        entry_valid;

    modport source (
        output valid, command, data_byte, last_byte, entry_index, entry_mac,
               entry_ip, entry_valid,
        input  ready
    );
    modport sink (
        input  valid, command, data_byte, last_byte, entry_index, entry_mac,
               entry_ip, entry_valid,
        output ready
    );
endinterface

>>> rtl/pamf_out_if.sv
// pamf_out_if: output channel carrying reply and forward results
// uses no package
interface pamf_out_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [2:0]  peer_index;
    logic [47:0] peer_mac;
    logic [31:0] peer_ip;
    logic        last_of_run;

    modport source (
        output valid, action, peer_index, peer_mac, peer_ip, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, action, peer_index, peer_mac, peer_ip, last_of_run,
        output ready
    );
endinterface

>>> rtl/proxy_arp_and_mac_forward.sv
// proxy_arp_and_mac_forward: top level, configuration registers and part wiring
// depends on pamf_pkg, pamf_in_if, pamf_out_if, pamf_front, pamf_queue, pamf_back
// throughput: one input transaction per cycle while the job queue has room
// back end: writes finish in idle; a frame job scans, one result per matching peer
// path: a frame result passes the queue, the scan mask and the result register
// reset: synchronous active low, clears valid bits, queue, scan state and registers
// reset needs no clearing pass; the block takes transactions the next cycle
module proxy_arp_and_mac_forward #(
    parameter int PEER_SLOTS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    pamf_in_if.sink                       i_in,
    pamf_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pamf_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready
);

    logic [47:0]    r_own_mac;
    logic [31:0]    r_own_ip;
    logic           cfg_write;
    logic           push_valid, push_ready;
    logic           pop_valid, pop_ready;
    pamf_pkg::t_job push_job, pop_job;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mac <= '0;
            r_own_ip  <= '0;
        end else if (cfg_write) begin
            unique case (paddr[pamf_pkg::CFG_SEL_BIT])
                pamf_pkg::REG_OWN_MAC: r_own_mac <= pwdata[47:0];
                pamf_pkg::REG_OWN_IP:  r_own_ip  <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (paddr[pamf_pkg::CFG_SEL_BIT])
            pamf_pkg::REG_OWN_MAC: prdata = {16'd0, r_own_mac};
            pamf_pkg::REG_OWN_IP:  prdata = {32'd0, r_own_ip};
            default:               prdata = '0;
        endcase
    end

    pamf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_own_mac    (r_own_mac),
        .i_own_ip     (r_own_ip),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_job   (push_job)
    );

    pamf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_job   (push_job),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_job    (pop_job)
    );

    pamf_back #(
        .PEER_SLOTS (PEER_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (pop_valid),
        .o_job_ready (pop_ready),
        .i_job       (pop_job),
        .o_out       (o_out)
    );

endmodule

>>> rtl/pamf_front.sv
// pamf_front: byte capture and frame classification, pushes jobs to the queue
// depends on pamf_pkg and pamf_in_if
module pamf_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pamf_in_if.sink        i_in,
    input  logic [47:0]    i_own_mac,
    input  logic [31:0]    i_own_ip,
    output logic           o_push_valid,
    input  logic           i_push_ready,
    output pamf_pkg::t_job o_push_job
);

    logic [5:0]  r_len, n_len;
    logic [47:0] r_dest, n_dest;
    logic [47:0] r_src, n_src;
    logic [47:0] r_types, n_types;
    logic [31:0] r_sizes, n_sizes;
    logic [47:0] r_smac, n_smac;
    logic [31:0] r_sip, n_sip;
    logic [31:0] r_tip, n_tip;

    logic       accept;
    logic       byte_acc;
    logic       frame_end;
    logic [5:0] len_inc;
    logic       is_arp;
    logic       hdr_ok;

    assign i_in.ready = i_push_ready;
    assign accept     = i_in.valid & i_push_ready;
    assign byte_acc   = accept && (i_in.command == pamf_pkg::CMD_FRAME);
    assign frame_end  = byte_acc && i_in.last_byte;
    assign len_inc    = (r_len == pamf_pkg::LEN_MAX) ? r_len : r_len + 6'd1;

    // shift the byte into the header field its offset belongs to
    always_comb begin
        n_dest  = r_dest;
        n_src   = r_src;
        n_types = r_types;
        n_sizes = r_sizes;
        n_smac  = r_smac;
        n_sip   = r_sip;
        n_tip   = r_tip;
        n_len   = r_len;
        if (byte_acc) begin
            if (r_len < pamf_pkg::POS_SRC_MAC) begin
                n_dest = {r_dest[39:0], i_in.data_byte};
            end else if (r_len < pamf_pkg::POS_TYPES) begin
                n_src = {r_src[39:0], i_in.data_byte};
            end else if (r_len < pamf_pkg::POS_SIZES) begin
                n_types = {r_types[39:0], i_in.data_byte};
            end else if (r_len < pamf_pkg::POS_SND_MAC) begin
                n_sizes = {r_sizes[23:0], i_in.data_byte};
            end else if (r_len < pamf_pkg::POS_SND_IP) begin
                n_smac = {r_smac[39:0], i_in.data_byte};
            end else if (r_len < pamf_pkg::POS_TGT_MAC) begin
                n_sip = {r_sip[23:0], i_in.data_byte};
            end else if (r_len >= pamf_pkg::POS_TGT_IP && r_len < pamf_pkg::ARP_LEN) begin
                n_tip = {r_tip[23:0], i_in.data_byte};
            end
            n_len = i_in.last_byte ? 6'd0 : len_inc;
        end
    end

    // classify the finished frame on its last byte
    assign is_arp = (len_inc == pamf_pkg::ARP_LEN)
                 && (n_types[47:32] == pamf_pkg::ETHERTYPE_ARP)
                 && (n_types[15:0] == pamf_pkg::PTYPE_IPV4)
                 && (n_sizes[15:0] == pamf_pkg::OPER_REQUEST);

    assign hdr_ok = (n_src == i_own_mac)
                 && (n_smac == i_own_mac)
                 && (n_dest == pamf_pkg::BCAST_MAC)
                 && (n_types[31:16] == pamf_pkg::HTYPE_ETH)
                 && (n_sizes[31:24] == pamf_pkg::HSIZE_ETH)
                 && (n_sizes[23:16] == pamf_pkg::PSIZE_IPV4)
                 && (n_sip == i_own_ip);

    // build the job for the back end
    always_comb begin
        o_push_valid    = 1'b0;
        o_push_job.op   = pamf_pkg::JOB_FWD;
        o_push_job.idx  = i_in.entry_index;
        o_push_job.mac  = n_dest;
        o_push_job.ip   = n_tip;
        o_push_job.flag = (n_dest == pamf_pkg::BCAST_MAC);
        if (accept && i_in.command == pamf_pkg::CMD_TABLE) begin
            o_push_valid    = 1'b1;
            o_push_job.op   = pamf_pkg::JOB_WRITE;
            o_push_job.mac  = i_in.entry_mac;
            o_push_job.ip   = i_in.entry_ip;
            o_push_job.flag = i_in.entry_valid;
        end else if (frame_end && is_arp) begin
            o_push_valid  = hdr_ok;
            o_push_job.op = pamf_pkg::JOB_ARP;
        end else if (frame_end && len_inc >= pamf_pkg::ETH_HDR_LEN) begin
            o_push_valid = 1'b1;
        end
    end

    // length counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= 6'd0;
        end else begin
            r_len <= n_len;
        end
    end

    // captured header fields
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest  <= '0;
            r_src   <= '0;
            r_types <= '0;
            r_sizes <= '0;
            r_smac  <= '0;
            r_sip   <= '0;
            r_tip   <= '0;
        end else begin
            r_dest  <= n_dest;
            r_src   <= n_src;
            r_types <= n_types;
            r_sizes <= n_sizes;
            r_smac  <= n_smac;
            r_sip   <= n_sip;
            r_tip   <= n_tip;
        end
    end

endmodule

>>> rtl/pamf_queue.sv
// pamf_queue: short job queue between the front and back parts
// depends on pamf_pkg
module pamf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  pamf_pkg::t_job i_push_job,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output pamf_pkg::t_job o_pop_job
);

    localparam int DEPTH = pamf_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pamf_pkg::t_job r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic push, pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_mem[r_rd_ptr];
    assign push         = i_push_valid & o_push_ready;
    assign pop          = o_pop_valid & i_pop_ready;

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/pamf_back.sv
// pamf_back: peer table and scan engine, emits one result per matching peer
// depends on pamf_pkg and pamf_out_if
module pamf_back #(
    parameter int PEER_SLOTS = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    output logic           o_job_ready,
    input  pamf_pkg::t_job i_job,
    pamf_out_if.source     o_out
);

    localparam int SLOT_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;

    logic [47:0]           r_peer_mac [PEER_SLOTS];
    logic [31:0]           r_peer_ip  [PEER_SLOTS];
    logic [PEER_SLOTS-1:0] r_peer_valid;

    pamf_pkg::t_back_state r_state, n_state;
    logic [PEER_SLOTS-1:0] r_mask;
    logic                  r_action;

    logic                  r_out_valid;
    logic                  r_out_action;
    logic [2:0]            r_out_index;
    logic [47:0]           r_out_mac;
    logic [31:0]           r_out_ip;
    logic                  r_out_last;

    logic [PEER_SLOTS-1:0] scan_mask;
    logic [PEER_SLOTS-1:0] rest_mask;
    logic [SLOT_W-1:0]     sel;
    logic                  take_job;
    logic                  out_free;
    logic                  load;
    logic                  table_wr;

    // match every slot against the job in its own lane
    always_comb begin
        for (int i = 0; i < PEER_SLOTS; i++) begin
            if (i_job.op == pamf_pkg::JOB_ARP) begin
                scan_mask[i] = r_peer_valid[i] && (r_peer_ip[i] == i_job.ip);
            end else begin
                scan_mask[i] = r_peer_valid[i] && (i_job.flag || r_peer_mac[i] == i_job.mac);
            end
        end
    end

    // lowest pending slot
    always_comb begin
        sel = '0;
        for (int i = PEER_SLOTS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                sel = SLOT_W'(i);
            end
        end
    end

    assign rest_mask = r_mask & (r_mask - 1'b1);

    // control outputs
    always_comb begin
        o_job_ready = (r_state == pamf_pkg::BACK_IDLE);
        take_job    = o_job_ready & i_job_valid;
        table_wr    = take_job && (i_job.op == pamf_pkg::JOB_WRITE)
                   && (int'(i_job.idx) < PEER_SLOTS);
        out_free    = !r_out_valid || o_out.ready;
        load        = (r_state == pamf_pkg::BACK_SCAN) && (r_mask != '0) && out_free;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pamf_pkg::BACK_IDLE: begin
                if (take_job && i_job.op != pamf_pkg::JOB_WRITE) begin
                    n_state = pamf_pkg::BACK_SCAN;
                end
            end
            pamf_pkg::BACK_SCAN: begin
                if (r_mask == '0 || (load && rest_mask == '0)) begin
                    n_state = pamf_pkg::BACK_IDLE;
                end
            end
            default: n_state = pamf_pkg::BACK_IDLE;
        endcase
    end

    // peer table contents
    always_ff @(posedge i_clk) begin
        if (table_wr) begin
            r_peer_mac[SLOT_W'(i_job.idx)] <= i_job.mac;
            r_peer_ip[SLOT_W'(i_job.idx)]  <= i_job.ip;
        end
    end

    // valid bits, scan state and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peer_valid <= '0;
            r_state      <= pamf_pkg::BACK_IDLE;
            r_mask       <= '0;
            r_action     <= pamf_pkg::ACT_REPLY;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (table_wr) begin
                r_peer_valid[SLOT_W'(i_job.idx)] <= i_job.flag;
            end
            if (take_job && i_job.op != pamf_pkg::JOB_WRITE) begin
                r_mask   <= scan_mask;
                r_action <= (i_job.op == pamf_pkg::JOB_FWD) ? pamf_pkg::ACT_FORWARD
                                                           : pamf_pkg::ACT_REPLY;
            end else if (load) begin
                r_mask <= rest_mask;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_action <= r_action;
            r_out_index  <= 3'(sel);
            r_out_mac    <= r_peer_mac[sel];
            r_out_ip     <= r_peer_ip[sel];
            r_out_last   <= (rest_mask == '0);
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.action      = r_out_action;
    assign o_out.peer_index  = r_out_index;
    assign o_out.peer_mac    = r_out_mac;
    assign o_out.peer_ip     = r_out_ip;
    assign o_out.last_of_run = r_out_last;

endmodule

>>> rtl/pamf_checker.sv
// pamf_checker: port level assertions for proxy_arp_and_mac_forward, with its bind
// depends on pamf_pkg, pamf_in_if and pamf_out_if
module pamf_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    pamf_in_if.sink                        i_in,
    pamf_out_if.source                     o_out,
    input logic [63:0]                     prdata
);

    // a result waiting on the sink stays valid and keeps its index, mac and last flag
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.peer_index)
            && $stable(o_out.peer_mac) && $stable(o_out.last_of_run))
        else $error("result changed while stalled");

    // reset drops any pending result
    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("result valid right after reset");

    // reset empties the job queue, so input is taken right away
    a_reset_ready: assert property (@(posedge i_clk) !i_rst_n |=> i_in.ready)
        else $error("input not ready after reset");

    // reset clears the configuration registers
    a_reset_cfg: assert property (@(posedge i_clk) !i_rst_n |=> prdata == 64'd0)
        else $error("configuration not cleared by reset");

endmodule

bind proxy_arp_and_mac_forward pamf_checker u_pamf_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_in    (i_in),
    .o_out   (o_out),
    .prdata  (prdata)
);

>>> tb/sv/pamf_result_check.sv
// pamf_result_check: predictor and scoreboard for proxy_arp_and_mac_forward
// watches the input, output and register ports, predicts each result and compares
// depends on pamf_pkg, pamf_in_if and pamf_out_if
module pamf_result_check #(
    parameter int PEER_SLOTS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    pamf_in_if                              i_in_mon,
    pamf_out_if                             i_out_mon,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [pamf_pkg::CFG_ADDR_W-1:0] i_paddr,
    input  logic [63:0]                     i_pwdata,
    input  logic                            i_pready,
    output int                              o_pending,
    output int                              o_fail_count
);
    import pamf_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic        action;
        logic [2:0]  slot;
        logic [47:0] mac;
        logic [31:0] ip;
        logic        last;
    } t_peer_action;

    // predicted copy of the peer table and the registers
    logic [47:0] peer_mac [PEER_SLOTS];
    logic [31:0] peer_ip  [PEER_SLOTS];
    logic        peer_on  [PEER_SLOTS];
    logic [47:0] own_mac;
    logic [31:0] own_ip;

    // header bytes captured from the frame in progress
    logic [5:0]  frame_len;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [47:0] type_bits;   // ethertype, hardware type, protocol type
    logic [31:0] size_op;     // hardware size, protocol size, opcode
    logic [47:0] snd_mac;
    logic [31:0] snd_ip;
    logic [31:0] tgt_ip;

    t_peer_action pending_actions[$];
    t_peer_action got;
    t_peer_action want;
    int           fail_total = 0;

    function automatic void note_mismatch(input string what, input t_peer_action exp_r,
                                          input t_peer_action act_r);
        fail_total++;
        if (fail_total <= REPORT_LIMIT) begin
            $display("%s: expected action %0d slot %0d mac %h ip %h last %0d", what,
                     exp_r.action, exp_r.slot, exp_r.mac, exp_r.ip, exp_r.last);
            $display("    got action %0d slot %0d mac %h ip %h last %0d",
                     act_r.action, act_r.slot, act_r.mac, act_r.ip, act_r.last);
        end
    endfunction

    // peer scan at the end of a frame: arp replies or forwards, lowest slot first
    function automatic void scan_peers(input logic [5:0] len);
        t_peer_action run[$];
        t_peer_action r;
        logic         is_arp;
        logic         hdr_ok;
        logic         bcast;
        is_arp = len == ARP_LEN && type_bits[47:32] == ETHERTYPE_ARP
                 && type_bits[15:0] == PTYPE_IPV4 && size_op[15:0] == OPER_REQUEST;
        hdr_ok = src_mac == own_mac && snd_mac == own_mac && dst_mac == BCAST_MAC
                 && type_bits[31:16] == HTYPE_ETH && size_op[31:24] == HSIZE_ETH
                 && size_op[23:16] == PSIZE_IPV4 && snd_ip == own_ip;
        bcast = dst_mac == BCAST_MAC;
        for (int i = 0; i < PEER_SLOTS; i++) begin
            r = '{action: ACT_REPLY, slot: 3'(i), mac: peer_mac[i], ip: peer_ip[i],
                  last: 1'b0};
            if (is_arp) begin
                if (hdr_ok && peer_on[i] && tgt_ip == peer_ip[i])
                    run.push_back(r);
            end else if (len >= ETH_HDR_LEN && peer_on[i]
                         && (bcast || peer_mac[i] == dst_mac)) begin
                r.action = ACT_FORWARD;
                run.push_back(r);
            end
        end
        if (run.size() > 0)
            run[run.size() - 1].last = 1'b1;
        foreach (run[k])
            pending_actions.push_back(run[k]);
    endfunction

    // shift one frame byte into the header field at its position
    function automatic void take_frame_byte(input logic [7:0] b, input logic fin);
        logic [5:0] len;
        if (frame_len < POS_SRC_MAC)
            dst_mac = {dst_mac[39:0], b};
        else if (frame_len < POS_TYPES)
            src_mac = {src_mac[39:0], b};
        else if (frame_len < POS_SIZES)
            type_bits = {type_bits[39:0], b};
        else if (frame_len < POS_SND_MAC)
            size_op = {size_op[23:0], b};
        else if (frame_len < POS_SND_IP)
            snd_mac = {snd_mac[39:0], b};
        else if (frame_len < POS_TGT_MAC)
            snd_ip = {snd_ip[23:0], b};
        else if (frame_len >= POS_TGT_IP && frame_len < ARP_LEN)
            tgt_ip = {tgt_ip[23:0], b};
        if (frame_len < LEN_MAX)
            frame_len++;
        if (fin) begin
            len = frame_len;
            frame_len = '0;
            scan_peers(len);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PEER_SLOTS; i++) begin
                peer_mac[i] = '0;
                peer_ip[i]  = '0;
                peer_on[i]  = 1'b0;
            end
            own_mac   = '0;
            own_ip    = '0;
            frame_len = '0;
            dst_mac   = '0;
            src_mac   = '0;
            type_bits = '0;
            size_op   = '0;
            snd_mac   = '0;
            snd_ip    = '0;
            tgt_ip    = '0;
            pending_actions.delete();
        end else begin
            // register write
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[CFG_SEL_BIT] == REG_OWN_MAC)
                    own_mac = i_pwdata[47:0];
                else
                    own_ip = i_pwdata[31:0];
            end
            // result transaction against the oldest prediction
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = '{action: i_out_mon.action, slot: i_out_mon.peer_index,
                        mac: i_out_mon.peer_mac, ip: i_out_mon.peer_ip,
                        last: i_out_mon.last_of_run};
                if (pending_actions.size() == 0) begin
                    note_mismatch("unexpected result", '0, got);
                end else begin
                    want = pending_actions.pop_front();
                    if (got.action !== want.action || got.slot !== want.slot
                        || got.mac !== want.mac || got.ip !== want.ip
                        || got.last !== want.last)
                        note_mismatch("result mismatch", want, got);
                end
            end
            // input transaction: table write or frame byte
            if (i_in_mon.valid && i_in_mon.ready) begin
                if (i_in_mon.command == CMD_TABLE) begin
                    if (int'(i_in_mon.entry_index) < PEER_SLOTS) begin
                        peer_mac[i_in_mon.entry_index] = i_in_mon.entry_mac;
                        peer_ip[i_in_mon.entry_index]  = i_in_mon.entry_ip;
                        peer_on[i_in_mon.entry_index]  = i_in_mon.entry_valid;
                    end
                end else begin
                    take_frame_byte(i_in_mon.data_byte, i_in_mon.last_byte);
                end
            end
        end
        o_pending    <= pending_actions.size();
        o_fail_count <= fail_total;
    end

endmodule

>>> tb/sv/tb_proxy_arp_and_mac_forward.sv
// tb_proxy_arp_and_mac_forward: stimulus and verdict for proxy_arp_and_mac_forward
// drives frames, peer table writes and register writes; pamf_result_check does the checking
// depends on pamf_pkg, pamf_in_if, pamf_out_if, pamf_result_check and the block itself
module tb_proxy_arp_and_mac_forward;
    import pamf_pkg::*;

    localparam int PEER_SLOTS     = 8;
    localparam int PHASES         = 4;
    localparam int PHASE_ITEMS    = 65;
    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum int {
        FLAW_NONE,
        FLAW_DEST,
        FLAW_SRC,
        FLAW_ETYPE,
        FLAW_HTYPE,
        FLAW_PTYPE,
        FLAW_HSIZE,
        FLAW_PSIZE,
        FLAW_OPER,
        FLAW_SND_MAC,
        FLAW_SND_IP,
        FLAW_TGT_IP,
        FLAW_LEN
    } t_arp_flaw;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [63:0]           pwdata;
    logic [63:0]           prdata;
    logic                  pready;

    pamf_in_if  in_ch ();
    pamf_out_if out_ch ();

    int   pending;
    int   fail_count;
    int   quiet_cycles = 0;
    int   items_sent   = 0;
    logic no_gaps      = 1'b0;

    // what the table holds, used only to aim frames at peers
    logic [47:0] peer_mac_copy [PEER_SLOTS];
    logic [31:0] peer_ip_copy  [PEER_SLOTS];
    logic        peer_on_copy  [PEER_SLOTS];
    logic [47:0] mac_pool [4];
    logic [31:0] ip_pool  [4];
    logic [47:0] own_mac;
    logic [31:0] own_ip;
    logic [7:0]  frame_q[$];

    proxy_arp_and_mac_forward #(.PEER_SLOTS(PEER_SLOTS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    pamf_result_check #(.PEER_SLOTS(PEER_SLOTS)) result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side stalls at random except in the steady stretch
    always @(posedge i_clk) begin
        out_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 16);
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [47:0] rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[47:0];
    endfunction

    // random valid slot, or -1 when the table is empty
    function automatic int pick_peer();
        int live[$];
        for (int i = 0; i < PEER_SLOTS; i++)
            if (peer_on_copy[i])
                live.push_back(i);
        if (live.size() == 0)
            return -1;
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    task automatic cfg_write(input logic sel, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, {CFG_SEL_BIT{1'b0}}};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one input transaction, with random idle cycles ahead of it
    task automatic send_item(input logic cmd, input logic [7:0] b, input logic fin,
                             input logic [2:0] idx, input logic [47:0] mac,
                             input logic [31:0] ip, input logic vld);
        while (!no_gaps && $urandom_range(0, 99) < 16) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.command     <= cmd;
        in_ch.data_byte   <= b;
        in_ch.last_byte   <= fin;
        in_ch.entry_index <= idx;
        in_ch.entry_mac   <= mac;
        in_ch.entry_ip    <= ip;
        in_ch.entry_valid <= vld;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    // table write; byte and last flag carry noise since the block ignores them
    task automatic write_peer(input int idx, input logic [47:0] mac, input logic [31:0] ip,
                              input logic vld);
        peer_mac_copy[idx] = mac;
        peer_ip_copy[idx]  = ip;
        peer_on_copy[idx]  = vld;
        send_item(CMD_TABLE, 8'($urandom), 1'($urandom), 3'(idx), mac, ip, vld);
    endtask

    task automatic random_peer_write(input int idx, input logic vld);
        logic [47:0] mac;
        logic [31:0] ip;
        mac = ($urandom_range(0, 99) < 50) ? mac_pool[$urandom_range(0, 3)] : rand48();
        ip  = ($urandom_range(0, 99) < 60) ? ip_pool[$urandom_range(0, 3)] : $urandom;
        write_peer(idx, mac, ip, vld);
    endtask

    task automatic put_bytes(input logic [63:0] value, input int n);
        for (int k = n - 1; k >= 0; k--)
            frame_q.push_back(value[8*k +: 8]);
    endtask

    // plain frame of the given length, truncated below the header when short
    task automatic build_plain(input logic [47:0] dst, input int len);
        frame_q.delete();
        put_bytes(64'(dst), 6);
        put_bytes(64'(rand48()), 6);
        while (frame_q.size() < len)
            frame_q.push_back(8'($urandom));
        while (frame_q.size() > len)
            void'(frame_q.pop_back());
    endtask

    // arp request from us to broadcast, with at most one field broken
    task automatic build_arp(input t_arp_flaw flaw);
        logic [47:0] dst;
        logic [47:0] src;
        logic [47:0] smac;
        logic [15:0] etype;
        logic [15:0] htype;
        logic [15:0] ptype;
        logic [15:0] oper;
        logic [7:0]  hsize;
        logic [7:0]  psize;
        logic [31:0] sip;
        logic [31:0] tip;
        int          slot;
        dst   = BCAST_MAC;
        src   = own_mac;
        smac  = own_mac;
        etype = ETHERTYPE_ARP;
        htype = HTYPE_ETH;
        ptype = PTYPE_IPV4;
        oper  = OPER_REQUEST;
        hsize = HSIZE_ETH;
        psize = PSIZE_IPV4;
        sip   = own_ip;
        slot  = pick_peer();
        tip   = (slot >= 0) ? peer_ip_copy[slot] : $urandom;
        case (flaw)
            FLAW_DEST: begin
                dst     = rand48();
                dst[40] = 1'b0;
            end
            FLAW_SRC:     src   = own_mac ^ (rand48() | 48'd1);
            FLAW_SND_MAC: smac  = own_mac ^ (rand48() | 48'd1);
            FLAW_ETYPE:   etype = etype ^ 16'($urandom_range(1, 65535));
            FLAW_HTYPE:   htype = htype ^ 16'($urandom_range(1, 65535));
            FLAW_PTYPE:   ptype = ptype ^ 16'($urandom_range(1, 65535));
            FLAW_OPER:    oper  = oper ^ 16'($urandom_range(1, 65535));
            FLAW_HSIZE:   hsize = hsize ^ 8'($urandom_range(1, 255));
            FLAW_PSIZE:   psize = psize ^ 8'($urandom_range(1, 255));
            FLAW_SND_IP:  sip   = own_ip ^ ($urandom | 32'd1);
            FLAW_TGT_IP:  tip   = $urandom;
            default: ;
        endcase
        frame_q.delete();
        put_bytes(64'(dst), 6);
        put_bytes(64'(src), 6);
        put_bytes(64'({etype, htype, ptype}), 6);
        put_bytes(64'({hsize, psize, oper}), 4);
        put_bytes(64'(smac), 6);
        put_bytes(64'(sip), 4);
        put_bytes(64'(rand48()), 6);
        put_bytes(64'(tip), 4);
        // one byte short or one too many
        if (flaw == FLAW_LEN) begin
            if ($urandom_range(0, 1) == 1)
                void'(frame_q.pop_back());
            else
                frame_q.push_back(8'($urandom));
        end
    endtask

    // send the built frame, now and then with a table write in the middle
    task automatic send_frame();
        for (int k = 0; k < frame_q.size(); k++) begin
            if ($urandom_range(0, 99) < 3)
                random_peer_write($urandom_range(0, PEER_SLOTS - 1), 1'b1);
            send_item(CMD_FRAME, frame_q[k], k == frame_q.size() - 1, 3'($urandom),
                      rand48(), $urandom, 1'($urandom));
        end
        frame_q.delete();
    endtask

    // stop sending, wait for every predicted result, then let the back end settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int start;
        int kind;
        int slot;
        t_arp_flaw flaw;

        in_ch.valid       = 1'b0;
        in_ch.command     = CMD_FRAME;
        in_ch.data_byte   = '0;
        in_ch.last_byte   = 1'b0;
        in_ch.entry_index = '0;
        in_ch.entry_mac   = '0;
        in_ch.entry_ip    = '0;
        in_ch.entry_valid = 1'b0;
        out_ch.ready      = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        i_rst_n           = 1'b0;
        for (int i = 0; i < PEER_SLOTS; i++) begin
            peer_mac_copy[i] = '0;
            peer_ip_copy[i]  = '0;
            peer_on_copy[i]  = 1'b0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0)
                drain();
            // register settings: random, all ones, all zeros, random
            case (phase)
                1: begin
                    own_mac = '1;
                    own_ip  = '1;
                end
                2: begin
                    own_mac = '0;
                    own_ip  = '0;
                end
                default: begin
                    own_mac = rand48();
                    own_ip  = $urandom;
                end
            endcase
            for (int k = 0; k < 4; k++) begin
                mac_pool[k] = rand48();
                ip_pool[k]  = $urandom;
            end
            if (phase == 1) begin
                mac_pool[0] = BCAST_MAC;
                ip_pool[0]  = '1;
            end else if (phase == 2) begin
                mac_pool[0] = '0;
                ip_pool[0]  = '0;
            end
            cfg_write(REG_OWN_MAC, {16'($urandom), own_mac});
            cfg_write(REG_OWN_IP, {32'($urandom), own_ip});
            no_gaps = (phase == 2);

            // fill the whole table, all valid in the first phase
            for (int i = 0; i < PEER_SLOTS; i++)
                random_peer_write(i, phase == 0 || $urandom_range(0, 99) < 80);

            // directed: good request, full broadcast, runt, unicast, removed peer
            if (phase == 0) begin
                build_arp(FLAW_NONE);
                send_frame();
                build_plain(BCAST_MAC, ETH_HDR_LEN);
                send_frame();
                build_plain(BCAST_MAC, ETH_HDR_LEN - 1);
                send_frame();
                build_plain(peer_mac_copy[5], 15);
                send_frame();
                write_peer(5, peer_mac_copy[5], peer_ip_copy[5], 1'b0);
                build_plain(peer_mac_copy[5], 15);
                send_frame();
            end

            // random frames, mostly well formed arp requests and peer traffic
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 15)
                    random_peer_write($urandom_range(0, PEER_SLOTS - 1),
                                      $urandom_range(0, 99) < 75);
                kind = $urandom_range(0, 99);
                slot = pick_peer();
                if (kind < 40) begin
                    flaw = ($urandom_range(0, 99) < 55) ? FLAW_NONE
                         : t_arp_flaw'($urandom_range(int'(FLAW_DEST), int'(FLAW_LEN)));
                    build_arp(flaw);
                end else if (kind < 62) begin
                    build_plain((slot >= 0) ? peer_mac_copy[slot] : rand48(),
                                $urandom_range(14, 20));
                end else if (kind < 77) begin
                    build_plain(BCAST_MAC, $urandom_range(14, 20));
                end else if (kind < 85) begin
                    build_plain(($urandom_range(0, 1) == 1) ? BCAST_MAC : rand48(),
                                $urandom_range(1, 13));
                end else if (kind < 91) begin
                    build_plain(($urandom_range(0, 1) == 1 || slot < 0) ? BCAST_MAC
                                : peer_mac_copy[slot], $urandom_range(64, 72));
                end else begin
                    build_plain(rand48(), $urandom_range(14, 42));
                end
                send_frame();
            end
        end

        drain();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> filelist.f
rtl/pamf_pkg.sv
rtl/pamf_in_if.sv
rtl/pamf_out_if.sv
rtl/pamf_front.sv
rtl/pamf_queue.sv
rtl/pamf_back.sv
rtl/proxy_arp_and_mac_forward.sv
rtl/pamf_checker.sv
tb/sv/pamf_result_check.sv
tb/sv/tb_proxy_arp_and_mac_forward.sv
